/* sv/lsnl_pkg.sv */
// ----------------------------------------------------------------------------
// lsnl_pkg
// Shared widths, register indexes, layout state encoding and the layout
// descriptor passed from the layout builder to the site pipeline.
// ----------------------------------------------------------------------------
package lsnl_pkg;

    localparam int NUM_DIRS       = 4;
    localparam int COORD_W        = 8;
    localparam int DIM_W          = 9;
    localparam int NCL_W          = 5;
    localparam int NODE_W         = 16;
    localparam int IDX_W          = 32;
    localparam int SPN_W          = 33;
    localparam int ACROSS_W       = 17;
    localparam int PLANE_W        = 17;
    localparam int AREA_W         = 2 * DIM_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = DIM_W;
    localparam int MAX_DIM        = 256;
    localparam int MAX_NODES_LOG2 = 16;

    // one restoring-division bit per stage
    localparam int DIV_STAGES     = COORD_W;
    // capture + divider + two multiply stages + output register
    localparam int PIPE_LATENCY   = DIV_STAGES + 4;

    localparam logic [DIM_W-1:0]    DIM_RESET   = DIM_W'(8);
    localparam logic [PLANE_W-1:0]  PLANE_RESET = PLANE_W'(64);
    localparam logic [AREA_W-1:0]   AREA_RESET  = AREA_W'(64);
    localparam logic [SPN_W-1:0]    SPN_RESET   = SPN_W'(4096);

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DIM_T     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_NODE_LOG2 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LAST      = REG_NODE_LOG2;

    typedef logic [1:0] dir_t;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_SORT,
        LS_HALVE,
        LS_FINISH,
        LS_SPN
    } layout_state_t;

    typedef struct packed {
        logic [NUM_DIRS-1:0][DIM_W-1:0] dim;
        dir_t [NUM_DIRS-1:0]            order;
        logic [DIM_W-1:0]               rect_long;
        logic [DIM_W-1:0]               rect_second;
        logic [ACROSS_W-1:0]            across;
        logic [PLANE_W-1:0]             plane;
        logic [DIM_W-1:0]               ext2;
        logic [SPN_W-1:0]               spn;
        logic                           failed;
    } layout_t;

endpackage

/* sv/lsnl_div_pipe.sv */
// ----------------------------------------------------------------------------
// lsnl_div_pipe
// Pipelined restoring divider: one quotient bit per stage, coordinate-wide
// dividend, dimension-wide divisor; the user must hold it stable while items are in flight (not enforced here).
// ----------------------------------------------------------------------------
module lsnl_div_pipe (
    input  logic                         clk,
    input  logic [lsnl_pkg::COORD_W-1:0] num,
    input  logic [lsnl_pkg::DIM_W-1:0]   den,
    output logic [lsnl_pkg::COORD_W-1:0] quo,
    output logic [lsnl_pkg::COORD_W-1:0] rem
);
    import lsnl_pkg::*;

    logic [COORD_W-1:0] rem_reg  [DIV_STAGES];
    logic [COORD_W-1:0] numr_reg [DIV_STAGES];
    logic [COORD_W-1:0] quo_reg  [DIV_STAGES];

    logic [COORD_W-1:0] rem_in   [DIV_STAGES];
    logic [COORD_W-1:0] numr_in  [DIV_STAGES];
    logic [COORD_W-1:0] quo_in   [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [DIM_W-1:0] trial;
        logic [DIM_W-1:0] diff;
        logic             ge;

        if (i == 0) begin : g_first
            assign rem_in[i]  = '0;
            assign numr_in[i] = num;
            assign quo_in[i]  = '0;
        end
        else begin : g_rest
            assign rem_in[i]  = rem_reg[i-1];
            assign numr_in[i] = numr_reg[i-1];
            assign quo_in[i]  = quo_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_in[i], numr_in[i][COORD_W-1]};
            ge    = (trial >= den);
            diff  = trial - den;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            numr_reg[i] <= {numr_in[i][COORD_W-2:0], 1'b0};
            quo_reg[i]  <= {quo_in[i][COORD_W-2:0], ge};
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];
    assign rem = rem_reg[DIV_STAGES-1];

endmodule

/* sv/lsnl_layout.sv */
// ----------------------------------------------------------------------------
// lsnl_layout
// Holds the lattice extents and node count, and rebuilds the layout after
// each register write: direction sort, rectangle halving one step a cycle,
// then plane size and sites per node.
// ----------------------------------------------------------------------------
module lsnl_layout (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [lsnl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsnl_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            cfg_ready,
    output logic                            busy,
    output lsnl_pkg::layout_t               layout
);
    import lsnl_pkg::*;

    layout_state_t                  state_reg;
    layout_state_t                  state_next;
    logic [NUM_DIRS-1:0][DIM_W-1:0] dim_reg;
    logic [NCL_W-1:0]               ncl_reg;
    dir_t [NUM_DIRS-1:0]            order_reg;
    logic [DIM_W-1:0]               long_reg;
    logic [DIM_W-1:0]               sec_reg;
    logic [DIM_W-1:0]               e2_reg;
    logic [DIM_W-1:0]               e3_reg;
    logic [ACROSS_W-1:0]            across_reg;
    logic [PLANE_W-1:0]             plane_reg;
    logic [AREA_W-1:0]              area_reg;
    logic [SPN_W-1:0]               spn_reg;
    logic                           fail_reg;
    logic [NCL_W-1:0]               cnt_reg;

    logic                           cfg_hit;
    dir_t [NUM_DIRS-1:0]            rank;
    dir_t [NUM_DIRS-1:0]            ord_sorted;
    logic                           range_bad;
    logic                           long_first;
    logic                           long_even;
    logic                           sec_even;
    logic                           halve_long;
    logic                           halving_done;
    logic [AREA_W-1:0]              plane_full;
    logic [AREA_W-1:0]              area_full;
    logic [PLANE_W+AREA_W-1:0]      spn_full;

    assign cfg_hit = cfg_valid && cfg_ready && (cfg_index <= REG_LAST);

    // stable descending sort as a rank count: ties keep direction order
    always_comb
    begin
        ord_sorted = '0;
        range_bad  = 1'b0;
        for (int a = 0; a < NUM_DIRS; a++) begin
            rank[a] = '0;
            for (int b = 0; b < NUM_DIRS; b++) begin
                if ((dim_reg[b] > dim_reg[a]) || ((dim_reg[b] == dim_reg[a]) && (b < a))) begin
                    rank[a] = rank[a] + 2'd1;
                end
            end
            if ((dim_reg[a] == '0) || (dim_reg[a] > DIM_W'(MAX_DIM))) begin
                range_bad = 1'b1;
            end
        end
        for (int a = 0; a < NUM_DIRS; a++) begin
            ord_sorted[rank[a]] = dir_t'(a);
        end
    end

    always_comb
    begin
        long_first   = (long_reg >= sec_reg);
        long_even    = ~long_reg[0];
        sec_even     = ~sec_reg[0];
        halve_long   = (long_first && long_even) || (!long_first && !sec_even && long_even);
        halving_done = fail_reg || (cnt_reg == ncl_reg);
        plane_full   = e2_reg * e3_reg;
        area_full    = long_reg * sec_reg;
        spn_full     = plane_reg * area_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LS_IDLE:   state_next = LS_IDLE;
            LS_SORT:   state_next = LS_HALVE;
            LS_HALVE:  state_next = halving_done ? LS_FINISH : LS_HALVE;
            LS_FINISH: state_next = LS_SPN;
            LS_SPN:    state_next = LS_IDLE;
            default:   state_next = LS_IDLE;
        endcase
        if (cfg_hit) begin
            state_next = LS_SORT;
        end
    end

    // outputs
    always_comb
    begin
        cfg_ready          = 1'b1;
        busy               = (state_reg != LS_IDLE);
        layout.dim         = dim_reg;
        layout.order       = order_reg;
        layout.rect_long   = long_reg;
        layout.rect_second = sec_reg;
        layout.across      = across_reg;
        layout.plane       = plane_reg;
        layout.ext2        = e2_reg;
        layout.spn         = spn_reg;
        layout.failed      = fail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= LS_IDLE;
            dim_reg    <= {NUM_DIRS{DIM_RESET}};
            ncl_reg    <= '0;
        end
        else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DIM_X:     dim_reg[0] <= cfg_data;
                    REG_DIM_Y:     dim_reg[1] <= cfg_data;
                    REG_DIM_Z:     dim_reg[2] <= cfg_data;
                    REG_DIM_T:     dim_reg[3] <= cfg_data;
                    REG_NODE_LOG2: ncl_reg    <= cfg_data[NCL_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            order_reg  <= {2'd3, 2'd2, 2'd1, 2'd0};
            long_reg   <= DIM_RESET;
            sec_reg    <= DIM_RESET;
            e2_reg     <= DIM_RESET;
            e3_reg     <= DIM_RESET;
            across_reg <= ACROSS_W'(1);
            plane_reg  <= PLANE_RESET;
            area_reg   <= AREA_RESET;
            spn_reg    <= SPN_RESET;
            fail_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else begin
            unique case (state_reg)
                LS_IDLE: ;
                LS_SORT: begin
                    order_reg  <= ord_sorted;
                    long_reg   <= dim_reg[ord_sorted[0]];
                    sec_reg    <= dim_reg[ord_sorted[1]];
                    e2_reg     <= dim_reg[ord_sorted[2]];
                    e3_reg     <= dim_reg[ord_sorted[3]];
                    across_reg <= ACROSS_W'(1);
                    cnt_reg    <= '0;
                    fail_reg   <= range_bad || (ncl_reg > NCL_W'(MAX_NODES_LOG2));
                end
                LS_HALVE: begin
                    if (!halving_done) begin
                        cnt_reg <= cnt_reg + NCL_W'(1);
                        if (halve_long) begin
                            long_reg   <= long_reg >> 1;
                            across_reg <= across_reg << 1;
                        end
                        else if (sec_even) begin
                            sec_reg <= sec_reg >> 1;
                        end
                        else begin
                            fail_reg <= 1'b1;
                        end
                    end
                end
                LS_FINISH: begin
                    plane_reg <= plane_full[PLANE_W-1:0];
                    area_reg  <= area_full;
                    // each node holds the short-direction plane whole: both must be even
                    if (e2_reg[0] || e3_reg[0]) begin
                        fail_reg <= 1'b1;
                    end
                end
                LS_SPN: begin
                    spn_reg <= fail_reg ? '0 : spn_full[SPN_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

/* sv/lattice_site_node_layout_unit.sv */
// ----------------------------------------------------------------------------
// lattice_site_node_layout_unit
// Maps a 4-D lattice site to its owning node and its index on that node.
// ----------------------------------------------------------------------------
// Pipeline: a start that is taken passes the capture register, 8 divider
// stages, 2 multiply stages and the output register before done strobes.
// Throughput: one site per cycle while busy is low; the pipeline itself never stalls.
// After a register write busy stays high while the layout rebuilds: sort, then
// one halving step per cycle, then plane size and sites per node.
// Reset: asynchronous; pipeline empty, layout of an 8x8x8x8 lattice on one node.
module lattice_site_node_layout_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lsnl_pkg::COORD_W-1:0]    coord_x,
    input  logic [lsnl_pkg::COORD_W-1:0]    coord_y,
    input  logic [lsnl_pkg::COORD_W-1:0]    coord_z,
    input  logic [lsnl_pkg::COORD_W-1:0]    coord_t,
    output logic                            done,
    output logic [lsnl_pkg::NODE_W-1:0]     owner_node,
    output logic [lsnl_pkg::IDX_W-1:0]      site_index,
    output logic [lsnl_pkg::SPN_W-1:0]      sites_per_node,
    output logic                            layout_error,
    output logic                            bad_coordinate,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsnl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsnl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsnl_pkg::*;

    localparam int INNER_W = 2 * COORD_W + 1;
    localparam int LOW_W   = DIM_W + COORD_W + 1;
    localparam int RAW_W   = PLANE_W + INNER_W + 1;
    localparam int SUM_W   = RAW_W + 1;

    layout_t                          lay;
    logic                             lay_busy;
    logic                             accept;
    logic [NUM_DIRS-1:0][COORD_W-1:0] crd;
    logic                             bad_in;
    logic                             par_in;

    // capture stage
    logic                s1_valid_reg;
    logic [COORD_W-1:0]  s1_cl_reg;
    logic [COORD_W-1:0]  s1_cs_reg;
    logic [COORD_W-1:0]  s1_c2_reg;
    logic [COORD_W-1:0]  s1_c3_reg;
    logic                s1_bad_reg;
    logic                s1_par_reg;

    // sideband alongside the dividers
    logic                sb_valid_reg [DIV_STAGES];
    logic [COORD_W-1:0]  sb_c2_reg    [DIV_STAGES];
    logic [COORD_W-1:0]  sb_c3_reg    [DIV_STAGES];
    logic                sb_bad_reg   [DIV_STAGES];
    logic                sb_par_reg   [DIV_STAGES];

    logic [COORD_W-1:0]  ql;
    logic [COORD_W-1:0]  rl;
    logic [COORD_W-1:0]  qs;
    logic [COORD_W-1:0]  rs;

    // multiply stage 1
    logic                       m1_valid_reg;
    logic [COORD_W-1:0]         m1_ql_reg;
    logic [NODE_W-1:0]          m1_hi_reg;
    logic [INNER_W-1:0]         m1_inner_reg;
    logic [LOW_W-1:0]           m1_low_reg;
    logic                       m1_bad_reg;
    logic                       m1_par_reg;
    logic [ACROSS_W+COORD_W-1:0] hi_full;
    logic [INNER_W-1:0]         inner_next;
    logic [LOW_W-1:0]           low_next;

    // multiply stage 2
    logic                m2_valid_reg;
    logic [NODE_W-1:0]   m2_node_reg;
    logic [RAW_W-1:0]    m2_raw_reg;
    logic                m2_bad_reg;
    logic                m2_par_reg;
    logic [RAW_W-1:0]    raw_next;

    // output register
    logic                done_reg;
    logic [NODE_W-1:0]   owner_node_reg;
    logic [IDX_W-1:0]    site_index_reg;
    logic [SPN_W-1:0]    spn_out_reg;
    logic                layout_error_reg;
    logic                bad_coordinate_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                zero_out;

    lsnl_layout u_layout (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .busy      (lay_busy),
        .layout    (lay)
    );

    assign busy   = lay_busy;
    assign accept = start && !lay_busy;
    assign crd    = {coord_t, coord_z, coord_y, coord_x};

    always_comb
    begin
        bad_in = 1'b0;
        par_in = 1'b0;
        for (int a = 0; a < NUM_DIRS; a++) begin
            if ({1'b0, crd[a]} >= lay.dim[a]) begin
                bad_in = 1'b1;
            end
            par_in = par_in ^ crd[a][0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cl_reg  <= crd[lay.order[0]];
        s1_cs_reg  <= crd[lay.order[1]];
        s1_c2_reg  <= crd[lay.order[2]];
        s1_c3_reg  <= crd[lay.order[3]];
        s1_bad_reg <= bad_in;
        s1_par_reg <= par_in;
    end

    lsnl_div_pipe u_div_long (
        .clk (clk),
        .num (s1_cl_reg),
        .den (lay.rect_long),
        .quo (ql),
        .rem (rl)
    );

    lsnl_div_pipe u_div_second (
        .clk (clk),
        .num (s1_cs_reg),
        .den (lay.rect_second),
        .quo (qs),
        .rem (rs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                sb_valid_reg[i] <= 1'b0;
            end
        end
        else begin
            sb_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sb_c2_reg[0]  <= s1_c2_reg;
        sb_c3_reg[0]  <= s1_c3_reg;
        sb_bad_reg[0] <= s1_bad_reg;
        sb_par_reg[0] <= s1_par_reg;
        for (int i = 1; i < DIV_STAGES; i++) begin
            sb_c2_reg[i]  <= sb_c2_reg[i-1];
            sb_c3_reg[i]  <= sb_c3_reg[i-1];
            sb_bad_reg[i] <= sb_bad_reg[i-1];
            sb_par_reg[i] <= sb_par_reg[i-1];
        end
    end

    // node row offset, in-rectangle offset and short-plane offset
    always_comb
    begin
        hi_full    = lay.across * qs;
        inner_next = INNER_W'(rl) + INNER_W'(lay.rect_long * rs);
        low_next   = LOW_W'(sb_c2_reg[DIV_STAGES-1])
                   + LOW_W'(lay.ext2 * sb_c3_reg[DIV_STAGES-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else begin
            m1_valid_reg <= sb_valid_reg[DIV_STAGES-1];
            m2_valid_reg <= m1_valid_reg;
            done_reg     <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_ql_reg    <= ql;
        m1_hi_reg    <= hi_full[NODE_W-1:0];
        m1_inner_reg <= inner_next;
        m1_low_reg   <= low_next;
        m1_bad_reg   <= sb_bad_reg[DIV_STAGES-1];
        m1_par_reg   <= sb_par_reg[DIV_STAGES-1];
    end

    assign raw_next = RAW_W'(lay.plane * m1_inner_reg) + RAW_W'(m1_low_reg);

    always_ff @(posedge clk)
    begin
        m2_node_reg <= NODE_W'(m1_ql_reg) + m1_hi_reg;
        m2_raw_reg  <= raw_next;
        m2_bad_reg  <= m1_bad_reg;
        m2_par_reg  <= m1_par_reg;
    end

    // odd sites sit in the upper half of the node's storage
    always_comb
    begin
        sum_next = SUM_W'(m2_raw_reg) + (m2_par_reg ? SUM_W'(lay.spn) : '0);
        zero_out = lay.failed || m2_bad_reg;
    end

    always_ff @(posedge clk)
    begin
        owner_node_reg     <= zero_out ? '0 : m2_node_reg;
        site_index_reg     <= zero_out ? '0 : sum_next[IDX_W:1];
        spn_out_reg        <= lay.failed ? '0 : lay.spn;
        layout_error_reg   <= lay.failed;
        bad_coordinate_reg <= m2_bad_reg;
    end

    assign done           = done_reg;
    assign owner_node     = owner_node_reg;
    assign site_index     = site_index_reg;
    assign sites_per_node = spn_out_reg;
    assign layout_error   = layout_error_reg;
    assign bad_coordinate = bad_coordinate_reg;

endmodule

/* sv/lsnl_checker.sv */
// ----------------------------------------------------------------------------
// lsnl_checker
// Port-level checks for the lattice site layout unit: fixed latency in both
// directions, zeroed results on flags, rebuild after a register write.
// ----------------------------------------------------------------------------
module lsnl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [lsnl_pkg::COORD_W-1:0]    coord_x,
    input logic [lsnl_pkg::COORD_W-1:0]    coord_y,
    input logic [lsnl_pkg::COORD_W-1:0]    coord_z,
    input logic [lsnl_pkg::COORD_W-1:0]    coord_t,
    input logic                            done,
    input logic [lsnl_pkg::NODE_W-1:0]     owner_node,
    input logic [lsnl_pkg::IDX_W-1:0]      site_index,
    input logic [lsnl_pkg::SPN_W-1:0]      sites_per_node,
    input logic                            layout_error,
    input logic                            bad_coordinate,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [lsnl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [lsnl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsnl_pkg::*;

    // every accepted transaction is answered by a done strobe once it has passed the pipeline
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted transaction produced no result at fixed latency");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without a matching accepted transaction");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && layout_error) |->
            (owner_node == '0) && (site_index == '0) && (sites_per_node == '0))
        else $error("layout error result carries nonzero payload");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_coordinate) |-> (owner_node == '0) && (site_index == '0))
        else $error("bad coordinate result carries nonzero node or index");

    a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index <= REG_LAST)) |=> busy)
        else $error("register write did not start a layout rebuild");

endmodule

bind lattice_site_node_layout_unit lsnl_checker u_lsnl_checker (.*);

/* tb/tb_lattice_site_node_layout_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_site_node_layout_unit
// Drives site lookups through the layout unit under several lattice shapes
// and node counts. The scoreboard rebuilds the rectangle layout on every
// write to a defined register and predicts owner node, site index and flags per site.
// ----------------------------------------------------------------------------
module tb_lattice_site_node_layout_unit;
    import lsnl_pkg::*;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  idx;
        logic [SPN_W-1:0]  spn;
        logic              lerr;
        logic              bad;
    } site_result_t;

    class site_map_scoreboard;
        logic [DIM_W-1:0] dim [NUM_DIRS];
        logic [NCL_W-1:0] node_log2;
        int               order [NUM_DIRS];
        int               rect_long;
        int               rect_second;
        int               across;
        int               plane;
        bit               failed;
        site_result_t     pending [$];
        int               fails;

        function new();
            for (int a = 0; a < NUM_DIRS; a++)
                dim[a] = DIM_RESET;
            node_log2 = '0;
            fails = 0;
            rebuild();
        endfunction

        // sort directions longest first, then halve the long-by-second rectangle
        function void rebuild();
            int e [NUM_DIRS];
            int t;
            bit fail;
            fail = 0;
            for (int a = 0; a < NUM_DIRS; a++)
            begin
                order[a] = a;
                e[a] = dim[a];
                if (e[a] == 0 || e[a] > MAX_DIM)
                    fail = 1;
            end
            for (int a = NUM_DIRS - 1; a > 0; a--)
                for (int b = 0; b < a; b++)
                    if (e[order[b]] < e[order[b + 1]])
                    begin
                        t = order[b];
                        order[b] = order[b + 1];
                        order[b + 1] = t;
                    end
            if (node_log2 > MAX_NODES_LOG2)
                fail = 1;
            rect_long = e[order[0]];
            rect_second = e[order[1]];
            across = 1;
            plane = (e[order[2]] * e[order[3]]) & 'h1FFFF;
            if (!fail)
            begin
                for (int p = 0; p < node_log2; p++)
                begin
                    if ((rect_long >= rect_second && rect_long % 2 == 0) ||
                        (rect_long < rect_second && rect_second % 2 == 1 &&
                         rect_long % 2 == 0))
                    begin
                        rect_long = rect_long / 2;
                        across = across * 2;
                    end
                    else if (rect_second % 2 == 0)
                        rect_second = rect_second / 2;
                    else
                    begin
                        fail = 1;
                        break;
                    end
                end
                if (e[order[2]] % 2 != 0 || e[order[3]] % 2 != 0)
                    fail = 1;
            end
            failed = fail;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_DIM_X:     dim[0] = data;
                REG_DIM_Y:     dim[1] = data;
                REG_DIM_Z:     dim[2] = data;
                REG_DIM_T:     dim[3] = data;
                REG_NODE_LOG2: node_log2 = data[NCL_W-1:0];
                default:       return;
            endcase
            rebuild();
        endfunction

        function void note_site(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [COORD_W-1:0] cz, logic [COORD_W-1:0] ct);
            int                c [NUM_DIRS];
            bit                bad;
            longint unsigned   spn;
            longint unsigned   node;
            longint unsigned   idx;
            longint unsigned   raw;
            int                cl;
            int                cs;
            int                c2;
            int                c3;
            site_result_t      r;
            c[0] = cx;
            c[1] = cy;
            c[2] = cz;
            c[3] = ct;
            bad = 0;
            for (int a = 0; a < NUM_DIRS; a++)
                if (c[a] >= int'(dim[a]))
                    bad = 1;
            spn = failed ? 64'd0 :
                  longint'(plane) * longint'(rect_long) * longint'(rect_second);
            node = 0;
            idx = 0;
            if (!failed && !bad)
            begin
                cl = c[order[0]];
                cs = c[order[1]];
                c2 = c[order[2]];
                c3 = c[order[3]];
                node = longint'(cl / rect_long) + longint'(across) * longint'(cs / rect_second);
                raw = longint'(plane) * (longint'(cl % rect_long) +
                      longint'(rect_long) * longint'(cs % rect_second)) +
                      longint'(c2) + longint'(dim[order[2]]) * longint'(c3);
                // even sites fill the lower half of node storage
                if (((c[0] + c[1] + c[2] + c[3]) & 1) == 0)
                    idx = raw >> 1;
                else
                    idx = (raw + spn) >> 1;
            end
            r.node = node[NODE_W-1:0];
            r.idx = idx[IDX_W-1:0];
            r.spn = spn[SPN_W-1:0];
            r.lerr = failed;
            r.bad = bad;
            pending.push_back(r);
        endfunction

        function void check_site(site_result_t got);
            site_result_t want;
            bit           wrong;
            wrong = 0;
            if (pending.size() == 0)
            begin
                fails++;
                $error("result with no site pending: owner_node %0d site_index %0d",
                       got.node, got.idx);
                return;
            end
            want = pending.pop_front();
            if (got.node !== want.node)
            begin
                $error("owner_node: expected %0d, got %0d", want.node, got.node);
                wrong = 1;
            end
            if (got.idx !== want.idx)
            begin
                $error("site_index: expected %0d, got %0d", want.idx, got.idx);
                wrong = 1;
            end
            if (got.spn !== want.spn)
            begin
                $error("sites_per_node: expected %0d, got %0d", want.spn, got.spn);
                wrong = 1;
            end
            if (got.lerr !== want.lerr)
            begin
                $error("layout_error: expected %0d, got %0d", want.lerr, got.lerr);
                wrong = 1;
            end
            if (got.bad !== want.bad)
            begin
                $error("bad_coordinate: expected %0d, got %0d", want.bad, got.bad);
                wrong = 1;
            end
            if (wrong)
                fails++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_W-1:0]    coord_x;
    logic [COORD_W-1:0]    coord_y;
    logic [COORD_W-1:0]    coord_z;
    logic [COORD_W-1:0]    coord_t;
    logic                  done;
    logic [NODE_W-1:0]     owner_node;
    logic [IDX_W-1:0]      site_index;
    logic [SPN_W-1:0]      sites_per_node;
    logic                  layout_error;
    logic                  bad_coordinate;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    site_map_scoreboard sb = new();

    lattice_site_node_layout_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .coord_t        (coord_t),
        .done           (done),
        .owner_node     (owner_node),
        .site_index     (site_index),
        .sites_per_node (sites_per_node),
        .layout_error   (layout_error),
        .bad_coordinate (bad_coordinate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        site_result_t got;
        if (rst_n && done)
        begin
            got.node = owner_node;
            got.idx = site_index;
            got.spn = sites_per_node;
            got.lerr = layout_error;
            got.bad = bad_coordinate;
            sb.check_site(got);
        end
    end

    task automatic send_site(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] t);
        @(negedge clk);
        start <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        coord_t <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_site(x, y, z, t);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // lower start and let every pending lookup come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if ($urandom_range(0, 99) < 17)
            repeat ($urandom_range(1, 3))
                @(negedge clk);
    endtask

    task automatic set_layout(input int dx, input int dy, input int dz, input int dt,
                              input int nlog2);
        write_reg(REG_DIM_X, CFG_DATA_W'(dx));
        write_reg(REG_DIM_Y, CFG_DATA_W'(dy));
        write_reg(REG_DIM_Z, CFG_DATA_W'(dz));
        write_reg(REG_DIM_T, CFG_DATA_W'(dt));
        write_reg(REG_NODE_LOG2, CFG_DATA_W'(nlog2));
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int d);
        if (d == 0 || d > MAX_DIM || $urandom_range(0, 9) == 0)
            return COORD_W'($urandom_range(0, 255));
        return COORD_W'($urandom_range(0, d - 1));
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 2 * $urandom_range(1, MAX_DIM / 2);
        if (r < 90)
            return $urandom_range(1, MAX_DIM);
        return $urandom_range(0, 2 ** CFG_DATA_W - 1);
    endfunction

    // idle gaps before about 8% of sites, unless calm is set
    task automatic run_lookups(input int count, input bit calm);
        for (int i = 0; i < count; i++)
        begin
            if (!calm && $urandom_range(0, 99) < 8)
                hold_off($urandom_range(1, 4));
            send_site(pick_coord(sb.dim[0]), pick_coord(sb.dim[1]),
                      pick_coord(sb.dim[2]), pick_coord(sb.dim[3]));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        coord_t = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset layout: 8^4 lattice on one node
        send_site(0, 0, 0, 0);
        send_site(7, 7, 7, 7);
        send_site(1, 0, 0, 0);
        send_site(3, 5, 6, 2);
        send_site(8, 0, 0, 0);
        send_site(0, 0, 0, 8);
        send_site(255, 255, 255, 255);
        drain();

        // largest lattice on the most nodes
        set_layout(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, MAX_NODES_LOG2);
        send_site(0, 0, 0, 0);
        send_site(255, 255, 255, 255);
        send_site(170, 85, 170, 85);
        send_site(85, 170, 85, 170);
        drain();

        // unequal extents exercise the sort
        set_layout(200, 120, 256, 40, 6);
        send_site(199, 119, 255, 39);
        send_site(17, 100, 3, 21);
        drain();

        // both rectangle sides odd before enough pieces
        set_layout(3, 3, 2, 2, 1);
        send_site(1, 1, 1, 1);
        send_site(5, 0, 0, 0);
        drain();

        // odd extent in a short direction
        set_layout(8, 8, 3, 2, 0);
        send_site(0, 0, 0, 0);
        drain();

        // extents out of range
        set_layout(0, 8, 8, 8, 0);
        send_site(0, 0, 0, 0);
        drain();
        set_layout(2 ** CFG_DATA_W - 1, 300, 8, 8, 0);
        send_site(255, 0, 0, 0);
        drain();

        // node count beyond the limit
        set_layout(8, 8, 8, 8, MAX_NODES_LOG2 + 1);
        send_site(0, 0, 0, 0);
        drain();
        write_reg(REG_NODE_LOG2, '1);
        send_site(1, 2, 3, 4);
        drain();

        // writes to unused indexes leave the layout alone
        set_layout(8, 8, 8, 8, 2);
        for (int r = REG_LAST + 1; r < 2 ** CFG_IDX_W; r++)
        begin
            write_reg(CFG_IDX_W'(r), '1);
            write_reg(CFG_IDX_W'(r), '0);
        end
        send_site(7, 7, 7, 7);
        send_site(4, 4, 0, 1);
        drain();

        set_layout(2, 2, 2, 2, 2);
        send_site(1, 1, 0, 1);
        drain();
        set_layout(1, 1, 1, 1, 0);
        send_site(0, 0, 0, 0);
        drain();

        // long stretch with no gaps on the big lattice
        set_layout(MAX_DIM, MAX_DIM, 128, 64, 12);
        run_lookups(150, 1'b1);

        for (int ph = 0; ph < 11; ph++)
        begin
            set_layout(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                       ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_LAST + 1, 2 ** CFG_IDX_W - 1)),
                          CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
            run_lookups($urandom_range(50, 90), 1'b0);
        end

        repeat (PIPE_LATENCY + 4)
            @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
